// ===== rtl/wamm_pkg.sv =====
// Shared constants, types and helpers for the windowed axis min/max/mean block.
// No dependencies; used by windowed_axis_min_max_mean through scoped names.
package wamm_pkg;

	// Field widths of the sample, difference and result words, the axis count and the index width.
	localparam int RAW_W     = 13;
	localparam int D_W       = 14;
	localparam int OUT_W     = 16;
	localparam int AXES      = 3;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_X = 2'd0,
		CFG_OFFSET_Y = 2'd1,
		CFG_OFFSET_Z = 2'd2
	} cfg_index_t;

	typedef logic signed [RAW_W-1:0] raw_t;
	typedef logic signed [D_W-1:0]   diff_t;
	typedef logic signed [OUT_W-1:0] mg_t;

	// Clamp a signed value to the int16 range.
	function automatic mg_t sat16(input logic signed [31:0] v);
		mg_t r;
		if (v > 32'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/windowed_axis_min_max_mean.sv =====
// Windowed per-axis mean, minimum and maximum of three-axis accelerometer samples.
// Depends on wamm_pkg for widths, register indexes and the int16 clamp.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one x/y/z raw sample per beat.
//   Output channel (out_valid / out_stall) carries one result beat per WINDOW
//   input beats: per-axis mean, minimum and maximum in milli-g.
//   Offsets are written through wr_en / wr_index / wr_data; the user must do so
//   only while idle (unenforced); a write to an index beyond offset_z is dropped.
// Timing:
//   One input beat per cycle is sustained while in_stall stays low. A window's
//   result passes, after its last sample is accepted, through the difference
//   register, accumulator, magnitude stage, reciprocal multiply, then output.
//   The constant-divisor mean uses one reciprocal multiplier per axis in its own stage.
// Reset:
//   arst_n clears offsets, the sample count and every valid flag; the first
//   sample after reset opens a new window.
// Stall:
//   A stalled result holds in the output register while samples keep flowing
//   into the accumulator; in_stall rises only when a window completes and the
//   stages behind it are all full with the output stalled.
module windowed_axis_min_max_mean #(
	parameter int WINDOW = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  wr_en,
	input  logic [wamm_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [wamm_pkg::RAW_W-1:0]            wr_data,
	// sample channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [wamm_pkg::RAW_W-1:0]     raw_x,
	input  logic signed [wamm_pkg::RAW_W-1:0]     raw_y,
	input  logic signed [wamm_pkg::RAW_W-1:0]     raw_z,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [wamm_pkg::OUT_W-1:0]     mean_x_mg,
	output logic signed [wamm_pkg::OUT_W-1:0]     mean_y_mg,
	output logic signed [wamm_pkg::OUT_W-1:0]     mean_z_mg,
	output logic signed [wamm_pkg::OUT_W-1:0]     least_x_mg,
	output logic signed [wamm_pkg::OUT_W-1:0]     least_y_mg,
	output logic signed [wamm_pkg::OUT_W-1:0]     least_z_mg,
	output logic signed [wamm_pkg::OUT_W-1:0]     most_x_mg,
	output logic signed [wamm_pkg::OUT_W-1:0]     most_y_mg,
	output logic signed [wamm_pkg::OUT_W-1:0]     most_z_mg
);

	localparam int AXES   = wamm_pkg::AXES;
	localparam int D_W    = wamm_pkg::D_W;
	localparam int OUT_W  = wamm_pkg::OUT_W;
	localparam int LOG_W  = $clog2(WINDOW);
	localparam int CNT_W  = LOG_W;
	localparam int SUM_W  = D_W + LOG_W;
	localparam int MAG_W  = SUM_W + 1;
	localparam int SHIFT  = MAG_W + LOG_W;
	localparam int RCP_W  = SHIFT;
	localparam int PROD_W = MAG_W + RCP_W;
	localparam longint unsigned RCP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW - 1);
	localparam logic [RCP_W-1:0] RCP_V = RCP[RCP_W-1:0];

	// Per-axis views of the ports.
	wamm_pkg::raw_t raw [AXES];
	assign raw[0] = raw_x;
	assign raw[1] = raw_y;
	assign raw[2] = raw_z;

	// Configuration
	wamm_pkg::raw_t offset_q [AXES];

	// Difference stage
	logic            v_s1;
	wamm_pkg::diff_t d_s1 [AXES];

	// Accumulator
	logic [CNT_W-1:0]          count_q;
	logic signed [SUM_W-1:0]   sum_q [AXES];
	wamm_pkg::diff_t           min_q [AXES];
	wamm_pkg::diff_t           max_q [AXES];

	// Window result stages
	logic                    v_s2, v_s3, v_s4;
	logic signed [SUM_W-1:0] sum_s2 [AXES];
	wamm_pkg::diff_t         min_s2 [AXES];
	wamm_pkg::diff_t         max_s2 [AXES];
	logic                    neg_s3 [AXES];
	logic [MAG_W-1:0]        mag_s3 [AXES];
	wamm_pkg::mg_t           least_s3 [AXES];
	wamm_pkg::mg_t           most_s3 [AXES];
	logic                    neg_s4 [AXES];
	logic [PROD_W-1:0]       prod_s4 [AXES];
	wamm_pkg::mg_t           least_s4 [AXES];
	wamm_pkg::mg_t           most_s4 [AXES];

	// Output register
	logic          out_valid_q;
	wamm_pkg::mg_t mean_q [AXES];
	wamm_pkg::mg_t least_q [AXES];
	wamm_pkg::mg_t most_q [AXES];

	// Flow control: each stage moves when the one behind it is empty or moving.
	logic out_free, s4_free, s3_free, s2_free, s1_last, s1_go, s1_free, acc_en, in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign s4_free  = !v_s4 || out_free;
	assign s3_free  = !v_s3 || s4_free;
	assign s2_free  = !v_s2 || s3_free;
	assign s1_last  = (count_q == LAST_CNT);
	assign s1_go    = !s1_last || s2_free;
	assign s1_free  = !v_s1 || s1_go;
	assign acc_en   = v_s1 && s1_go;
	assign in_take  = in_valid && s1_free;
	assign in_stall = !s1_free;

	// Per-axis combinational work of each stage.
	wamm_pkg::diff_t         d_in [AXES];
	logic signed [SUM_W-1:0] sum_nx [AXES];
	wamm_pkg::diff_t         min_nx [AXES];
	wamm_pkg::diff_t         max_nx [AXES];
	logic signed [SUM_W-1:0] abs_s2 [AXES];
	logic [MAG_W-1:0]        q_s4 [AXES];
	logic signed [MAG_W:0]   mean_s4 [AXES];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			// subtract offset
			d_in[a] = D_W'(raw[a]) - D_W'(offset_q[a]);
			// seed on the first sample, else fold in
			if (count_q == '0) begin
				sum_nx[a] = SUM_W'(d_s1[a]);
				min_nx[a] = d_s1[a];
				max_nx[a] = d_s1[a];
			end else begin
				sum_nx[a] = sum_q[a] + SUM_W'(d_s1[a]);
				min_nx[a] = min_q[a];
				max_nx[a] = max_q[a];
				if (d_s1[a] > max_q[a]) begin
					max_nx[a] = d_s1[a];
				end else if (d_s1[a] < min_q[a]) begin
					min_nx[a] = d_s1[a];
				end
			end
			// magnitude of the window sum
			abs_s2[a] = sum_s2[a][SUM_W-1] ? -sum_s2[a] : sum_s2[a];
			// quotient from the reciprocal product, sign restored
			q_s4[a] = prod_s4[a][SHIFT +: MAG_W];
			mean_s4[a] = neg_s4[a] ? -$signed({1'b0, q_s4[a]}) : $signed({1'b0, q_s4[a]});
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				offset_q[a] <= '0;
			end
			v_s1        <= 1'b0;
			count_q     <= '0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// offset writes; unknown indexes are dropped
			if (wr_en) begin
				unique case (wamm_pkg::cfg_index_t'(wr_index))
					wamm_pkg::CFG_OFFSET_X: offset_q[0] <= wr_data;
					wamm_pkg::CFG_OFFSET_Y: offset_q[1] <= wr_data;
					wamm_pkg::CFG_OFFSET_Z: offset_q[2] <= wr_data;
					default: ;
				endcase
			end
			if (s1_free) begin
				v_s1 <= in_valid;
			end
			// advance the window count, wrap at the last sample
			if (acc_en) begin
				count_q <= s1_last ? '0 : count_q + 1'b1;
			end
			if (s2_free) begin
				v_s2 <= acc_en && s1_last;
			end
			if (s3_free) begin
				v_s3 <= v_s2;
			end
			if (s4_free) begin
				v_s4 <= v_s3;
			end
			if (out_free) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		for (int a = 0; a < AXES; a++) begin
			if (in_take) begin
				d_s1[a] <= d_in[a];
			end
			if (acc_en) begin
				sum_q[a] <= sum_nx[a];
				min_q[a] <= min_nx[a];
				max_q[a] <= max_nx[a];
			end
			if (s2_free && acc_en && s1_last) begin
				sum_s2[a] <= sum_nx[a];
				min_s2[a] <= min_nx[a];
				max_s2[a] <= max_nx[a];
			end
			if (s3_free && v_s2) begin
				neg_s3[a]   <= sum_s2[a][SUM_W-1];
				mag_s3[a]   <= {abs_s2[a][SUM_W-2:0], 2'b00};
				least_s3[a] <= {min_s2[a], 2'b00};
				most_s3[a]  <= {max_s2[a], 2'b00};
			end
			if (s4_free && v_s3) begin
				neg_s4[a]   <= neg_s3[a];
				prod_s4[a]  <= PROD_W'(mag_s3[a]) * PROD_W'(RCP_V);
				least_s4[a] <= least_s3[a];
				most_s4[a]  <= most_s3[a];
			end
			if (out_free && v_s4) begin
				mean_q[a]  <= wamm_pkg::sat16(32'(mean_s4[a]));
				least_q[a] <= wamm_pkg::sat16(32'(least_s4[a]));
				most_q[a]  <= wamm_pkg::sat16(32'(most_s4[a]));
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_x_mg  = mean_q[0];
	assign mean_y_mg  = mean_q[1];
	assign mean_z_mg  = mean_q[2];
	assign least_x_mg = least_q[0];
	assign least_y_mg = least_q[1];
	assign least_z_mg = least_q[2];
	assign most_x_mg  = most_q[0];
	assign most_y_mg  = most_q[1];
	assign most_z_mg  = most_q[2];

	// A result appears only after the multiply stage held a window.
	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s4))
		else $error("result beat without a finished window");

	// A non-final sample advances the window count by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc_en && !s1_last |=> count_q == $past(count_q) + 1'b1)
		else $error("window count did not advance");

	// Mid-window, each axis keeps its minimum no larger than its maximum.
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> (min_q[0] <= max_q[0]) && (min_q[1] <= max_q[1])
			&& (min_q[2] <= max_q[2]))
		else $error("axis minimum above maximum");

	// A completing window with full stages behind it must hold the input.
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && s1_last && !s2_free |-> in_stall)
		else $error("window end accepted with no room behind it");

endmodule
